[hdl/lbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants for the LED blink controller.
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int NUM_CHANNELS_DEF = 3;
    localparam int TIME_BITS_DEF    = 32;

    // Widths fixed by the item format
    localparam int NOW_W  = 32;
    localparam int SEL_W  = 3;
    localparam int ARG_W  = 32;
    localparam int MASK_W = 3;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_COMMAND = 1'b1
    } op_e_t;

    typedef enum logic [1:0] {
        CMD_BLINK = 2'd0,
        CMD_ONCE  = 2'd1,
        CMD_SET   = 2'd2,
        CMD_BAD   = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_BLINK = 2'd1,
        MODE_ONCE  = 2'd2
    } mode_e_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_LED = 2'd1,
        ST_BAD_CMD = 2'd2
    } status_e_t;

    typedef struct packed {
        op_e_t             operation;
        logic [NOW_W-1:0]  now_ms;
        logic [SEL_W-1:0]  led_select;
        cmd_e_t            command;
        logic [ARG_W-1:0]  first_arg;
        logic [ARG_W-1:0]  second_arg;
    } item_t;

    // Per-channel control for one item
    typedef struct packed {
        logic   advance;  // item in the input register is processed this cycle
        logic   tick;     // item is a time tick
        logic   sel;      // item is a command addressed to this channel
        cmd_e_t cmd;
    } chan_ctrl_t;

endpackage

[hdl/lbc_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_in_stage
// Input register: captures one item and holds it until it is processed.
// ----------------------------------------------------------------------------
module lbc_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  lbc_pkg::item_t item_in,
    input  logic           advance,
    output logic           item_valid,
    output lbc_pkg::item_t item_out
);
    import lbc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // Room when empty or when the held item leaves this cycle
    assign in_stall = valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_in;
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

[hdl/lbc_channel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_channel
// State and update logic of one LED channel.
// ----------------------------------------------------------------------------
module lbc_channel #(
    parameter int TIME_BITS = lbc_pkg::TIME_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lbc_pkg::chan_ctrl_t      ctrl,
    input  logic [TIME_BITS-1:0]     now,
    input  logic [lbc_pkg::ARG_W-1:0] first_arg,
    input  logic [lbc_pkg::ARG_W-1:0] second_arg,
    output logic                     lit_next
);
    import lbc_pkg::*;

    mode_e_t              mode_reg, mode_next;
    logic [ARG_W-1:0]     on_reg, on_next;
    logic [ARG_W-1:0]     off_reg, off_next;
    logic                 lit_reg, lit_nxt;
    logic [TIME_BITS-1:0] deadline_reg, deadline_next;
    logic [ARG_W-1:0]     dur;
    logic [TIME_BITS-1:0] sum;
    logic                 due;

    assign due = (now >= deadline_reg);

    // Duration for the single deadline adder
    always_comb
    begin
        if (ctrl.tick)
            dur = lit_reg ? off_reg : on_reg;
        else
            dur = first_arg;
    end

    assign sum = now + TIME_BITS'(dur);

    always_comb
    begin
        mode_next     = mode_reg;
        on_next       = on_reg;
        off_next      = off_reg;
        lit_nxt       = lit_reg;
        deadline_next = deadline_reg;
        if (ctrl.tick)
        begin
            case (mode_reg)
                MODE_BLINK:
                begin
                    if (due)
                    begin
                        lit_nxt       = !lit_reg;
                        deadline_next = sum;
                    end
                end
                MODE_ONCE:
                begin
                    if (due)
                    begin
                        mode_next     = MODE_IDLE;
                        lit_nxt       = 1'b0;
                        deadline_next = now;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (ctrl.sel)
        begin
            case (ctrl.cmd)
                CMD_BLINK:
                begin
                    mode_next     = MODE_BLINK;
                    on_next       = first_arg;
                    off_next      = second_arg;
                    lit_nxt       = 1'b1;
                    deadline_next = sum;
                end
                CMD_ONCE:
                begin
                    mode_next     = MODE_ONCE;
                    lit_nxt       = 1'b1;
                    deadline_next = sum;
                end
                CMD_SET:
                begin
                    mode_next     = MODE_IDLE;
                    lit_nxt       = (first_arg != '0);
                    deadline_next = now;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            on_reg       <= '0;
            off_reg      <= '0;
            lit_reg      <= 1'b0;
            deadline_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            mode_reg     <= mode_next;
            on_reg       <= on_next;
            off_reg      <= off_next;
            lit_reg      <= lit_nxt;
            deadline_reg <= deadline_next;
        end
    end

    assign lit_next = lit_nxt;

endmodule

[hdl/led_blink_controller_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_controller_core
// Multi-channel LED blink engine: ticks advance blinking and single flashes,
// commands start blinking, start a flash, or set an LED steadily.
// ----------------------------------------------------------------------------
// Each item waits in an input register while every channel evaluates it in
// parallel (one deadline add and one unsigned compare per channel), and the
// result lands in an output register. Throughput is one item per clock unless
// out_stall holds the full output register; an accepted item passes the input
// register, then the output register, which raises out_valid.
// in_stall rises only when the input register holds an item and the output
// register holds an untaken result under out_stall. Deadlines wrap modulo
// 2**TIME_BITS. lit_mask/pin_mask carry the first three channels; bits of
// channels that do not exist read 0 in both.
// ----------------------------------------------------------------------------
module led_blink_controller_core #(
    parameter int NUM_CHANNELS = lbc_pkg::NUM_CHANNELS_DEF,
    parameter int TIME_BITS    = lbc_pkg::TIME_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // item input
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       operation,
    input  logic [lbc_pkg::NOW_W-1:0]  now_ms,
    input  logic [lbc_pkg::SEL_W-1:0]  led_select,
    input  logic [1:0]                 command,
    input  logic [lbc_pkg::ARG_W-1:0]  first_arg,
    input  logic [lbc_pkg::ARG_W-1:0]  second_arg,
    // result output
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [lbc_pkg::MASK_W-1:0] lit_mask,
    output logic [lbc_pkg::MASK_W-1:0] pin_mask,
    output logic [1:0]                 status
);
    import lbc_pkg::*;

    localparam logic [SEL_W:0] CH_LIMIT = (SEL_W + 1)'(NUM_CHANNELS);

    item_t                 item_in;
    item_t                 item;
    logic                  item_valid;
    logic                  advance;
    logic [TIME_BITS-1:0]  now;
    logic                  is_tick;
    logic                  sel_ok;
    logic [NUM_CHANNELS-1:0] lit_next;

    logic                  out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]     lit_mask_reg, lit_mask_next;
    logic [MASK_W-1:0]     pin_mask_reg, pin_mask_next;
    status_e_t             status_reg, status_next;

    assign item_in.operation  = op_e_t'(operation);
    assign item_in.now_ms     = now_ms;
    assign item_in.led_select = led_select;
    assign item_in.command    = cmd_e_t'(command);
    assign item_in.first_arg  = first_arg;
    assign item_in.second_arg = second_arg;

    // Process the held item when the result register is free or draining
    assign advance = item_valid && (!out_valid_reg || !out_stall);

    lbc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item_in    (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item_out   (item)
    );

    assign now     = TIME_BITS'(item.now_ms);
    assign is_tick = (item.operation == OP_TICK);
    assign sel_ok  = ({1'b0, item.led_select} < CH_LIMIT);

    // One channel instance per LED, all evaluated in the same cycle
    for (genvar i = 0; i < NUM_CHANNELS; i++)
    begin : g_ch
        chan_ctrl_t ctrl;

        assign ctrl.advance = advance;
        assign ctrl.tick    = is_tick;
        assign ctrl.sel     = !is_tick && (item.led_select == SEL_W'(i));
        assign ctrl.cmd     = item.command;

        lbc_channel #(
            .TIME_BITS (TIME_BITS)
        ) u_ch (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .now        (now),
            .first_arg  (item.first_arg),
            .second_arg (item.second_arg),
            .lit_next   (lit_next[i])
        );
    end

    // Masks: only channels that exist drive a bit
    for (genvar b = 0; b < MASK_W; b++)
    begin : g_mask
        if (b < NUM_CHANNELS)
        begin : g_on
            assign lit_mask_next[b] = lit_next[b];
            assign pin_mask_next[b] = !lit_next[b];
        end
        else
        begin : g_off
            assign lit_mask_next[b] = 1'b0;
            assign pin_mask_next[b] = 1'b0;
        end
    end

    // Bad LED id is checked before the command code
    always_comb
    begin
        if (is_tick)
            status_next = ST_OK;
        else if (!sel_ok)
            status_next = ST_BAD_LED;
        else if (item.command == CMD_BAD)
            status_next = ST_BAD_CMD;
        else
            status_next = ST_OK;
    end

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lit_mask_reg <= lit_mask_next;
            pin_mask_reg <= pin_mask_next;
            status_reg   <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign lit_mask  = lit_mask_reg;
    assign pin_mask  = pin_mask_reg;
    assign status    = status_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // An LED is never both lit and driven as unlit
    a_mask_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((lit_mask & pin_mask) == '0))
        else $error("lit_mask and pin_mask overlap");

    // Input back-pressure only comes from a stalled, full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output back-pressure");

    // A processed item always shows up as a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("processed item produced no result");

endmodule
